/* rtl/core/timestamp_ordered_stream_mux_macros.svh */
// Assertion macros used by the multiplexer datapath (tsmux_dp).
// Each macro samples on the rising edge of clk_i and is disabled in reset.
`ifndef TIMESTAMP_ORDERED_STREAM_MUX_MACROS_SVH
`define TIMESTAMP_ORDERED_STREAM_MUX_MACROS_SVH

// Property that must hold at every sampled edge.
`define TSMUX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies the consequent in the next one.
`define TSMUX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tsmux_pkg.sv */
// ----------------------------------------------------------------------------
// tsmux_pkg
// Shared types and constants of the timestamp ordered stream multiplexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsmux_pkg;

  localparam int STREAMS     = 4;
  localparam int QDEPTH      = 16;
  localparam int MAX_RESULTS = 64;
  localparam int SIDX_W      = $clog2(STREAMS);
  localparam int SLOT_W      = $clog2(QDEPTH);
  localparam int CNT_W       = $clog2(QDEPTH + 1);
  localparam int ADDR_W      = SIDX_W + SLOT_W;
  localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int TS_W        = 63;
  localparam int SIZE_W      = 24;
  localparam int MASK_W      = 4;

  typedef enum logic [1:0] {
    ST_EMIT = 2'd0,
    ST_DROP = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REQ_PACKET = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DROP,
    S_SCAN,
    S_PICK,
    S_UPDATE,
    S_EMIT,
    S_FINISH
  } state_e;

  // One result beat.
  typedef struct packed {
    status_e             status;
    logic [SIDX_W-1:0]   stream;
    logic [TS_W-1:0]     dts;
    logic                pts_valid;
    logic [TS_W-1:0]     pts;
    logic                key;
    logic [SIZE_W-1:0]   size;
    logic                after_header;
    logic                last;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic enq;
    logic remove;
    logic scan_step;
    logic read;
    logic pop;
    logic emit;
    logic finish;
    logic drop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_remove;
    logic live;
    logic full;
    logic dts_valid;
    logic scan_unknown;
    logic scan_last;
    logic best_ok;
    logic size_nz;
    logic pend_valid;
    logic out_free;
    logic n_last;
  } stat_t;

endpackage

/* rtl/core/tsmux_ctrl.sv */
// ----------------------------------------------------------------------------
// tsmux_ctrl
// Sequencer: accepts an item and either drops it, or enqueues or removes it and runs the release loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsmux_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tsmux_pkg::stat_t st_i,
  output tsmux_pkg::cmd_t  cmd_o
);
  import tsmux_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (st_i.is_remove) begin
          state_d = S_SCAN;
        end else if (!st_i.live || !st_i.dts_valid || st_i.full) begin
          state_d = S_DROP;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_DROP: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (st_i.scan_unknown) begin
          state_d = S_FINISH;
        end else if (st_i.scan_last) begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        state_d = st_i.best_ok ? S_UPDATE : S_FINISH;
      end
      S_UPDATE: begin
        state_d = st_i.size_nz ? S_EMIT : S_SCAN;
      end
      S_EMIT: begin
        if (!st_i.pend_valid || st_i.out_free) begin
          state_d = st_i.n_last ? S_FINISH : S_SCAN;
        end
      end
      S_FINISH: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CHECK: begin
        if (st_i.is_remove) begin
          cmd_o.remove = st_i.live;
        end else begin
          cmd_o.enq = st_i.live && st_i.dts_valid && !st_i.full;
        end
      end
      S_DROP:   cmd_o.drop = st_i.out_free;
      S_SCAN:   cmd_o.scan_step = 1'b1;
      S_PICK:   cmd_o.read = 1'b1;
      S_UPDATE: cmd_o.pop = 1'b1;
      S_EMIT:   cmd_o.emit = !st_i.pend_valid || st_i.out_free;
      S_FINISH: cmd_o.finish = st_i.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/core/tsmux_dp.sv */
// ----------------------------------------------------------------------------
// tsmux_dp
// Datapath: packet store, per-stream queue state, minimum scan, result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "timestamp_ordered_stream_mux_macros.svh"

module tsmux_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tsmux_pkg::cmd_t                      cmd_i,
  output tsmux_pkg::stat_t                     st_o,
  input  logic                                 cfg_we_i,
  input  logic [tsmux_pkg::MASK_W-1:0]         cfg_wdata_i,
  input  logic                                 req_type_i,
  input  logic [tsmux_pkg::SIDX_W-1:0]         stream_index_i,
  input  logic                                 dts_valid_i,
  input  logic [tsmux_pkg::TS_W-1:0]           dts_i,
  input  logic                                 pts_valid_i,
  input  logic [tsmux_pkg::TS_W-1:0]           pts_i,
  input  logic                                 duration_valid_i,
  input  logic [tsmux_pkg::TS_W-1:0]           duration_i,
  input  logic                                 key_frame_i,
  input  logic [tsmux_pkg::SIZE_W-1:0]         payload_size_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output tsmux_pkg::res_t                      out_o
);
  import tsmux_pkg::*;

  typedef struct packed {
    logic [TS_W-1:0]   dts;
    logic              pts_valid;
    logic [TS_W-1:0]   pts;
    logic              dur_valid;
    logic [TS_W-1:0]   dur;
    logic              key;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Captured input beat.
  logic              req_q;
  logic [SIDX_W-1:0] idx_q;
  logic              dtsv_q;
  entry_t            in_q;

  // Per-stream control state.
  logic [STREAMS-1:0] live_q, live_d;
  logic               hdone_q, hdone_d;
  logic [SLOT_W-1:0]  head_q [STREAMS];
  logic [SLOT_W-1:0]  head_d [STREAMS];
  logic [CNT_W-1:0]   count_q [STREAMS];
  logic [CNT_W-1:0]   count_d [STREAMS];
  logic [STREAMS-1:0] expv_q, expv_d;
  logic [TS_W-1:0]    exp_q [STREAMS];
  logic [TS_W-1:0]    exp_d [STREAMS];

  // Scan and loop state.
  logic [SIDX_W-1:0]  scan_idx_q, scan_idx_d;
  logic               best_v_q, best_v_d;
  logic [SIDX_W-1:0]  best_q, best_d;
  logic [TS_W-1:0]    best_dts_q, best_dts_d;
  logic [NCNT_W-1:0]  n_q, n_d;

  // Result staging.
  logic pend_v_q, pend_v_d;
  res_t pend_q, pend_d;
  logic out_v_q, out_v_d;
  res_t out_q, out_d;

  // Packet store, one row per stream and slot.
  entry_t            mem [STREAMS*QDEPTH];
  entry_t            rd_a_q;
  entry_t            rd_b_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [SLOT_W-1:0] wr_slot;

  logic              base_v, take, out_free;
  logic [TS_W:0]     dur_sum;

  assign out_free = !out_v_q || out_ready_i;
  assign wr_slot  = head_q[idx_q] + count_q[idx_q][SLOT_W-1:0];
  assign wr_addr  = {idx_q, wr_slot};
  assign rd_addr_a = {best_q, head_q[best_q]};
  assign rd_addr_b = {best_q, head_q[best_q] + 1'b1};

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) mem[wr_addr] <= in_q;
    if (cmd_i.read) begin
      rd_a_q <= mem[rd_addr_a];
      rd_b_q <= mem[rd_addr_b];
    end
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q          <= req_type_i;
      idx_q          <= stream_index_i;
      dtsv_q         <= dts_valid_i;
      in_q.dts       <= dts_i;
      in_q.pts_valid <= pts_valid_i;
      in_q.pts       <= pts_valid_i ? pts_i : '0;
      in_q.dur_valid <= duration_valid_i;
      in_q.dur       <= duration_i;
      in_q.key       <= key_frame_i;
      in_q.size      <= payload_size_i;
    end
  end

  // Scan step: keep the live stream with the lowest known expected DTS.
  assign base_v  = (scan_idx_q == '0) ? 1'b0 : best_v_q;
  assign take    = live_q[scan_idx_q] && expv_q[scan_idx_q] &&
                   (!base_v || exp_q[scan_idx_q] < best_dts_q);
  assign dur_sum = {1'b0, exp_q[best_q]} + {1'b0, rd_a_q.dur};

  // Next-state logic of the control registers.
  always_comb begin
    live_d     = live_q;
    hdone_d    = hdone_q;
    head_d     = head_q;
    count_d    = count_q;
    expv_d     = expv_q;
    exp_d      = exp_q;
    scan_idx_d = scan_idx_q;
    best_v_d   = best_v_q;
    best_d     = best_q;
    best_dts_d = best_dts_q;
    n_d        = n_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_d      = out_q;

    if (cmd_i.load) n_d = '0;

    // Enqueue a descriptor; an empty queue takes its DTS as expected.
    if (cmd_i.enq) begin
      count_d[idx_q] = count_q[idx_q] + 1'b1;
      if (count_q[idx_q] == '0) begin
        expv_d[idx_q] = 1'b1;
        exp_d[idx_q]  = in_q.dts;
      end
    end

    // Stream removal.
    if (cmd_i.remove) begin
      live_d[idx_q]  = 1'b0;
      head_d[idx_q]  = '0;
      count_d[idx_q] = '0;
      expv_d[idx_q]  = 1'b0;
    end

    if (cmd_i.scan_step) begin
      best_v_d   = base_v || take;
      if (take) begin
        best_d     = scan_idx_q;
        best_dts_d = exp_q[scan_idx_q];
      end
      scan_idx_d = (live_q[scan_idx_q] && !expv_q[scan_idx_q]) ? '0 : scan_idx_q + 1'b1;
    end

    // Pop the head of the chosen stream and advance its expected DTS.
    if (cmd_i.pop) begin
      head_d[best_q]  = head_q[best_q] + 1'b1;
      count_d[best_q] = count_q[best_q] - 1'b1;
      if (count_q[best_q] == CNT_W'(1)) begin
        expv_d[best_q] = rd_a_q.dur_valid;
        exp_d[best_q]  = dur_sum[TS_W] ? '1 : dur_sum[TS_W-1:0];
      end else begin
        exp_d[best_q]  = rd_b_q.dts;
      end
    end

    // New emission: older pending beat goes out, not last.
    if (cmd_i.emit) begin
      if (pend_v_q) begin
        out_v_d = 1'b1;
        out_d   = pend_q;
      end
      pend_v_d            = 1'b1;
      pend_d.status       = ST_EMIT;
      pend_d.stream       = best_q;
      pend_d.dts          = rd_a_q.dts;
      pend_d.pts_valid    = rd_a_q.pts_valid;
      pend_d.pts          = rd_a_q.pts;
      pend_d.key          = rd_a_q.key;
      pend_d.size         = rd_a_q.size;
      pend_d.after_header = !hdone_q;
      pend_d.last         = 1'b0;
      hdone_d             = 1'b1;
      n_d                 = n_q + 1'b1;
    end

    // End of release: final beat carries last.
    if (cmd_i.finish) begin
      out_v_d = 1'b1;
      if (pend_v_q) begin
        out_d = pend_q;
      end else begin
        out_d        = '0;
        out_d.status = ST_NONE;
      end
      out_d.last = 1'b1;
      pend_v_d   = 1'b0;
    end

    if (cmd_i.drop) begin
      out_v_d      = 1'b1;
      out_d        = '0;
      out_d.status = ST_DROP;
      out_d.last   = 1'b1;
    end

    // Mask writes reshape the live set until the first emission.
    if (cfg_we_i && !hdone_q) begin
      for (int s = 0; s < STREAMS; s++) begin
        if (live_q[s] && !cfg_wdata_i[s]) begin
          head_d[s]  = '0;
          count_d[s] = '0;
          expv_d[s]  = 1'b0;
        end
      end
      live_d = cfg_wdata_i[STREAMS-1:0];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q     <= STREAMS'(1);
      hdone_q    <= 1'b0;
      expv_q     <= '0;
      scan_idx_q <= '0;
      best_v_q   <= 1'b0;
      best_q     <= '0;
      n_q        <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      for (int s = 0; s < STREAMS; s++) begin
        head_q[s]  <= '0;
        count_q[s] <= '0;
      end
    end else begin
      live_q     <= live_d;
      hdone_q    <= hdone_d;
      expv_q     <= expv_d;
      scan_idx_q <= scan_idx_d;
      best_v_q   <= best_v_d;
      best_q     <= best_d;
      n_q        <= n_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      head_q     <= head_d;
      count_q    <= count_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    exp_q      <= exp_d;
    best_dts_q <= best_dts_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  // Status to the controller.
  always_comb begin
    st_o.is_remove    = (req_q == REQ_REMOVE);
    st_o.live         = live_q[idx_q];
    st_o.full         = (count_q[idx_q] == CNT_W'(QDEPTH));
    st_o.dts_valid    = dtsv_q;
    st_o.scan_unknown = live_q[scan_idx_q] && !expv_q[scan_idx_q];
    st_o.scan_last    = (scan_idx_q == SIDX_W'(STREAMS - 1));
    st_o.best_ok      = best_v_q && (count_q[best_q] != '0);
    st_o.size_nz      = (rd_a_q.size != '0);
    st_o.pend_valid   = pend_v_q;
    st_o.out_free     = out_free;
    st_o.n_last       = (n_q == NCNT_W'(MAX_RESULTS - 1));
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  `TSMUX_ASSERT(a_count_bound, count_q[best_q] <= CNT_W'(QDEPTH), "queue count above depth")
  `TSMUX_ASSERT(a_push_free, !(cmd_i.finish || cmd_i.drop) || out_free, "push into busy output")
  `TSMUX_ASSERT(a_pop_nonempty, !cmd_i.pop || count_q[best_q] != '0, "pop from empty queue")
  `TSMUX_ASSERT_NEXT(a_emit_header, cmd_i.emit, hdone_q && pend_v_q, "emission not recorded")

endmodule

/* rtl/core/timestamp_ordered_stream_mux.sv */
// ----------------------------------------------------------------------------
// timestamp_ordered_stream_mux
// Merges descriptors of up to four streams into one output in DTS order.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries one descriptor or
// stream removal per beat. Every input beat yields one or more result beats on
// the output channel (out_valid_o/out_ready_i); last_o marks the final one.
// The user must write the stream mask through cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce this.
// Flow: a check state, then each release attempt runs a scan of the four
// streams (one stream per cycle through the shared comparator), a store
// read state and an update state, plus an emit state per emitted packet.
// The next item is accepted once the final beat sits in the output register.
// Reset: all queues empty, every expected DTS unknown, only stream 0 live.
// Stall: the release loop holds in place while the output register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_ordered_stream_mux (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsmux_pkg::MASK_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [tsmux_pkg::SIDX_W-1:0]    stream_index_i,
  input  logic                            dts_valid_i,
  input  logic [tsmux_pkg::TS_W-1:0]      dts_i,
  input  logic                            pts_valid_i,
  input  logic [tsmux_pkg::TS_W-1:0]      pts_i,
  input  logic                            duration_valid_i,
  input  logic [tsmux_pkg::TS_W-1:0]      duration_i,
  input  logic                            key_frame_i,
  input  logic [tsmux_pkg::SIZE_W-1:0]    payload_size_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [tsmux_pkg::SIDX_W-1:0]    out_stream_o,
  output logic [tsmux_pkg::TS_W-1:0]      out_dts_o,
  output logic                            out_pts_valid_o,
  output logic [tsmux_pkg::TS_W-1:0]      out_pts_o,
  output logic                            out_key_o,
  output logic [tsmux_pkg::SIZE_W-1:0]    out_size_o,
  output logic                            after_header_o,
  output logic                            last_o
);
  import tsmux_pkg::*;

  cmd_t  cmd;
  stat_t st;
  res_t  res;

  // Sequencer.
  tsmux_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath.
  tsmux_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_type_i       (req_type_i),
    .stream_index_i   (stream_index_i),
    .dts_valid_i      (dts_valid_i),
    .dts_i            (dts_i),
    .pts_valid_i      (pts_valid_i),
    .pts_i            (pts_i),
    .duration_valid_i (duration_valid_i),
    .duration_i       (duration_i),
    .key_frame_i      (key_frame_i),
    .payload_size_i   (payload_size_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .out_o            (res)
  );

  // Result fields.
  assign status_o        = res.status;
  assign out_stream_o    = res.stream;
  assign out_dts_o       = res.dts;
  assign out_pts_valid_o = res.pts_valid;
  assign out_pts_o       = res.pts;
  assign out_key_o       = res.key;
  assign out_size_o      = res.size;
  assign after_header_o  = res.after_header;
  assign last_o          = res.last;

endmodule
